// ----- sv/shortest_job_next_scheduler_defines.svh -----
// assertion macros for the shortest-job-next scheduler rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef SHORTEST_JOB_NEXT_SCHEDULER_DEFINES_SVH
`define SHORTEST_JOB_NEXT_SCHEDULER_DEFINES_SVH

// condition holds at every edge out of reset
`define SJN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SJN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SJN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sjn_pkg.sv -----
// shared types, command codes and helpers of the shortest-job-next scheduler
// no dependencies
package sjn_pkg;

  localparam int unsigned ID_W       = 16;
  localparam int unsigned IN_TIME_W  = 16;
  localparam int unsigned OUT_TIME_W = 22;

  localparam logic [OUT_TIME_W-1:0] SAT_MAX = '1;

  // command codes carried in tuser of the input word
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic run_start;
    logic scan_start;
    logic scan_step;
    logic dispatch;
    logic emit_empty;
    logic run_end;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic last_dispatch;
    logic out_free;
  } sts_t;

  function automatic logic [OUT_TIME_W-1:0] sat_time(input logic [63:0] v);
    logic [OUT_TIME_W-1:0] r;
    r = (v > 64'(SAT_MAX)) ? SAT_MAX : v[OUT_TIME_W-1:0];
    return r;
  endfunction

endpackage

// ----- sv/sjn_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module sjn_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sjn_ctrl.sv -----
// controller state machine of the shortest-job-next scheduler
// depends on sjn_pkg for the state, command and status types
module sjn_ctrl
  import sjn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_cmd_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   empty_q, empty_d;

  always_comb begin
    state_d    = state_q;
    empty_d    = empty_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (sts_i.count_zero) begin
            empty_d = 1'b1;
            state_d = ST_EMIT;
          end else begin
            cmd_o.run_start  = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          if (empty_q) begin
            cmd_o.emit_empty = 1'b1;
            empty_d          = 1'b0;
            state_d          = ST_IDLE;
          end else begin
            cmd_o.dispatch = 1'b1;
            if (sts_i.last_dispatch) begin
              cmd_o.run_end = 1'b1;
              state_d       = ST_IDLE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        empty_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      empty_q <= empty_d;
    end
  end

endmodule

// ----- sv/sjn_dp.sv -----
// datapath of the shortest-job-next scheduler: job table, scan, dispatch, output word
// depends on sjn_pkg, sjn_ram and the assertion macro header
`include "shortest_job_next_scheduler_defines.svh"

module sjn_dp
  import sjn_pkg::*;
#(
  parameter int unsigned MAX_JOBS  = 32,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [ID_W-1:0]       job_id_i,
  input  logic [IN_TIME_W-1:0]  arrival_time_i,
  input  logic [IN_TIME_W-1:0]  service_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ID_W-1:0]       job_id_res_o,
  output logic [OUT_TIME_W-1:0] start_time_o,
  output logic [OUT_TIME_W-1:0] turnaround_o,
  output logic                  last_o,
  output logic                  overflow_o,
  output logic                  empty_run_o
);

  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_JOBS);
  localparam int unsigned NOW_W = TIME_BITS + CNT_W;
  localparam int unsigned ENT_W = ID_W + 2 * TIME_BITS;

  // table control
  logic [CNT_W-1:0]    count_q;
  logic                dropped_q;
  logic [MAX_JOBS-1:0] fin_q;
  logic                full;

  // scan pipeline
  logic [IDX_W-1:0] rd_idx_q;
  logic             vld_q;
  logic [IDX_W-1:0] idx_q;
  logic [ENT_W-1:0] wr_data, rd_data;
  logic [ID_W-1:0]      rd_id;
  logic [TIME_BITS-1:0] rd_arr, rd_svc;
  logic                 rd_open, rd_arrived, upd_a, upd_b;

  // run time and dispatch count
  logic [NOW_W-1:0] now_q;
  logic [CNT_W-1:0] done_q;

  // best arrived job (a) and earliest pending job (b)
  logic                 a_vld_q, b_vld_q;
  logic [IDX_W-1:0]     a_idx_q, b_idx_q;
  logic [ID_W-1:0]      a_id_q, b_id_q;
  logic [TIME_BITS-1:0] a_arr_q, b_arr_q, a_svc_q, b_svc_q;

  // chosen job
  logic [IDX_W-1:0]     sel_idx;
  logic [ID_W-1:0]      sel_id;
  logic [TIME_BITS-1:0] sel_arr, sel_svc;
  logic [NOW_W-1:0]     sel_start, sel_finish, sel_turn;

  // output register
  logic                  out_valid_q;
  logic [ID_W-1:0]       out_id_q;
  logic [OUT_TIME_W-1:0] out_start_q, out_turn_q;
  logic                  out_last_q, out_ovf_q, out_empty_q;
  logic                  out_free;

  assign full    = (count_q == CNT_W'(MAX_JOBS));
  assign wr_data = {TIME_BITS'(service_time_i), TIME_BITS'(arrival_time_i), job_id_i};

  sjn_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_JOBS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load && !full),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(wr_data),
    .raddr_i(rd_idx_q),
    .rdata_o(rd_data)
  );

  assign rd_id      = rd_data[ID_W-1:0];
  assign rd_arr     = rd_data[ID_W +: TIME_BITS];
  assign rd_svc     = rd_data[ID_W+TIME_BITS +: TIME_BITS];
  assign rd_open    = vld_q && !fin_q[idx_q];
  assign rd_arrived = (NOW_W'(rd_arr) <= now_q);
  // later entries win ties, hence <=
  assign upd_a = rd_open && rd_arrived && (!a_vld_q || rd_svc <= a_svc_q);
  assign upd_b = rd_open && (!b_vld_q || rd_arr < b_arr_q ||
                             (rd_arr == b_arr_q && rd_svc <= b_svc_q));

  // nothing arrived: jump to the earliest arrival, whose group b tracked
  always_comb begin
    if (a_vld_q) begin
      sel_idx   = a_idx_q;
      sel_id    = a_id_q;
      sel_arr   = a_arr_q;
      sel_svc   = a_svc_q;
      sel_start = now_q;
    end else begin
      sel_idx   = b_idx_q;
      sel_id    = b_id_q;
      sel_arr   = b_arr_q;
      sel_svc   = b_svc_q;
      sel_start = NOW_W'(b_arr_q);
    end
  end

  assign sel_finish = sel_start + NOW_W'(sel_svc);
  assign sel_turn   = sel_finish - NOW_W'(sel_arr);

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      fin_q       <= '0;
      rd_idx_q    <= '0;
      vld_q       <= 1'b0;
      now_q       <= '0;
      done_q      <= '0;
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (full) begin
          dropped_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.run_start) begin
        now_q  <= '0;
        done_q <= '0;
      end
      vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        rd_idx_q <= '0;
        a_vld_q  <= 1'b0;
        b_vld_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          rd_idx_q <= rd_idx_q + IDX_W'(1);
        end
        if (upd_a) begin
          a_vld_q <= 1'b1;
        end
        if (upd_b) begin
          b_vld_q <= 1'b1;
        end
      end
      if (cmd_i.dispatch) begin
        now_q  <= sel_finish;
        done_q <= done_q + CNT_W'(1);
      end
      // the final dispatch of a run clears the whole table state
      if (cmd_i.run_end) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
        fin_q     <= '0;
      end else if (cmd_i.dispatch) begin
        fin_q[sel_idx] <= 1'b1;
      end
      if (cmd_i.dispatch || cmd_i.emit_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= rd_idx_q;
    if (upd_a && !cmd_i.scan_start) begin
      a_idx_q <= idx_q;
      a_id_q  <= rd_id;
      a_arr_q <= rd_arr;
      a_svc_q <= rd_svc;
    end
    if (upd_b && !cmd_i.scan_start) begin
      b_idx_q <= idx_q;
      b_id_q  <= rd_id;
      b_arr_q <= rd_arr;
      b_svc_q <= rd_svc;
    end
    if (cmd_i.dispatch) begin
      out_id_q    <= sel_id;
      out_start_q <= sat_time(64'(sel_start));
      out_turn_q  <= sat_time(64'(sel_turn));
      out_last_q  <= (done_q + CNT_W'(1) == count_q);
      out_ovf_q   <= dropped_q;
      out_empty_q <= 1'b0;
    end else if (cmd_i.emit_empty) begin
      out_id_q    <= '0;
      out_start_q <= '0;
      out_turn_q  <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_empty_q <= 1'b1;
    end
  end

  assign sts_o.count_zero    = (count_q == '0);
  assign sts_o.last_issue    = (CNT_W'(rd_idx_q) == count_q - CNT_W'(1));
  assign sts_o.last_dispatch = (done_q + CNT_W'(1) == count_q);
  assign sts_o.out_free      = out_free;

  assign out_valid_o  = out_valid_q;
  assign job_id_res_o = out_id_q;
  assign start_time_o = out_start_q;
  assign turnaround_o = out_turn_q;
  assign last_o       = out_last_q;
  assign overflow_o   = out_ovf_q;
  assign empty_run_o  = out_empty_q;

  `SJN_ASSERT_ALWAYS(a_count_in_range, count_q <= CNT_W'(MAX_JOBS),
                     "job count beyond table depth")
  `SJN_ASSERT_IMP(a_dispatch_has_pick, cmd_i.dispatch, a_vld_q || b_vld_q,
                  "dispatch without any candidate job")
  `SJN_ASSERT_NXT(a_run_end_clears, cmd_i.run_end,
                  count_q == '0 && fin_q == '0 && !dropped_q,
                  "table not emptied after run")

endmodule

// ----- sv/shortest_job_next_scheduler.sv -----
// top level of the non-preemptive shortest-job-next scheduler
// depends on sjn_pkg, sjn_ctrl and sjn_dp
//
// input stream: one word per command. tuser = 0 loads a job (id, arrival,
// service) into the next free table slot; a load into a full table is
// dropped and remembered as overflow. tuser = 1 runs the schedule.
// a run emits one output word per stored job in dispatch order; each pick
// takes the unfinished, already-arrived job with least service time (ties
// go to the later load), and if none has arrived time jumps to the earliest
// pending arrival. tlast marks the final job of the run. a run on an empty
// table emits a single word with empty_run set and all else zero.
// each pick of a run scans the job table through one ram read port, one entry per
// cycle, then the read pipeline drains and the output register is loaded.
// the input is taken only while the block is idle; a finished word may sit
// in the output register while a new command is accepted.
// if the receiver stalls, the word holds in the output register and the
// next pick waits. reset empties the table and clears overflow and the
// output valid; the table ram itself is not cleared.
module shortest_job_next_scheduler
  import sjn_pkg::*;
#(
  parameter int unsigned MAX_JOBS  = 32,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // job_id[15:0], arrival_time[31:16], service_time[47:32]
  input  logic        s_axis_tuser_i,   // command[0]
  // output word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // job_id_res[15:0], start_time[37:16], turnaround[59:38]
  output logic        m_axis_tlast_o,   // last
  output logic [1:0]  m_axis_tuser_o    // overflow[0], empty_run[1]
);

  cmd_t cmd;
  sts_t sts;

  logic [ID_W-1:0]       job_id_res;
  logic [OUT_TIME_W-1:0] start_time, turnaround;
  logic                  overflow, empty_run;

  // sequencing: idle, scan, pipeline drain, emit
  sjn_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_cmd_i  (s_axis_tuser_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // job table, min search, time keeping and the output register
  sjn_dp #(
    .MAX_JOBS (MAX_JOBS),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .job_id_i      (s_axis_tdata_i[15:0]),
    .arrival_time_i(s_axis_tdata_i[31:16]),
    .service_time_i(s_axis_tdata_i[47:32]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .job_id_res_o  (job_id_res),
    .start_time_o  (start_time),
    .turnaround_o  (turnaround),
    .last_o        (m_axis_tlast_o),
    .overflow_o    (overflow),
    .empty_run_o   (empty_run)
  );

  // pad to whole bytes
  assign m_axis_tdata_o = {4'b0000, turnaround, start_time, job_id_res};
  assign m_axis_tuser_o = {empty_run, overflow};

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for the shortest-job-next scheduler: a queue-fed stream driver,
// a monitor that predicts every dispatch word and compares it field by field
// depends on sjn_pkg and shortest_job_next_scheduler
module tb;
  import sjn_pkg::*;

  localparam int TABLE_DEPTH   = 32;
  localparam int QUIET_LIMIT   = 4000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 1100;  // extra wait once no word is left to send or expected
  localparam logic [63:0] TIME_CEIL = 64'd4194303;

  // one command word waiting to be sent; hold keeps it back until all
  // dispatch words predicted so far have come out
  typedef struct packed {
    bit                   hold;
    logic [1:0]           phase;
    logic                 cmd;
    logic [ID_W-1:0]      job_id;
    logic [IN_TIME_W-1:0] arr;
    logic [IN_TIME_W-1:0] svc;
  } cmd_word_t;

  typedef struct packed {
    logic [ID_W-1:0]       job_id;
    logic [OUT_TIME_W-1:0] start_at;
    logic [OUT_TIME_W-1:0] turnaround;
    logic                  last;
    logic                  overflow;
    logic                  empty_run;
  } dispatch_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;  // job_id[15:0], arrival_time[31:16], service_time[47:32]
  logic        s_axis_tuser_i = 1'b0;  // command[0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;  // job_id_res[15:0], start_time[37:16], turnaround[59:38]
  logic        m_axis_tlast_o;  // last
  logic [1:0]  m_axis_tuser_o;  // overflow[0], empty_run[1]

  // idle mixes per phase: none, sender, receiver, both
  int send_idle_pct [4] = '{0, 79, 0, 38};
  int recv_stall_pct [4] = '{0, 0, 79, 38};

  cmd_word_t cmd_backlog [$];
  dispatch_t dispatch_expected [$];
  logic [1:0] rx_phase = '0;
  bit word_taken = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int loads_taken = 0;
  int runs_taken = 0;
  int dispatch_words = 0;
  int overflow_words = 0;
  int empty_words = 0;

  // scheduler table as the block should hold it
  logic [ID_W-1:0]      id_tbl [TABLE_DEPTH];
  logic [IN_TIME_W-1:0] arrival_tbl [TABLE_DEPTH];
  logic [IN_TIME_W-1:0] service_tbl [TABLE_DEPTH];
  bit                   dispatched [TABLE_DEPTH];
  int                   table_fill = 0;
  bit                   loads_dropped = 1'b0;

  shortest_job_next_scheduler u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // least service time among unfinished jobs that have arrived by now,
  // later entry wins a tie; -1 when none has arrived
  function automatic int shortest_ready(logic [63:0] now);
    int best;
    int k;
    best = -1;
    for (k = 0; k < table_fill; k++) begin
      if (!dispatched[k] && 64'(arrival_tbl[k]) <= now &&
          (best < 0 || service_tbl[k] <= service_tbl[best]))
        best = k;
    end
    return best;
  endfunction

  function automatic logic [OUT_TIME_W-1:0] clip_time(logic [63:0] v);
    return (v > TIME_CEIL) ? OUT_TIME_W'(TIME_CEIL) : v[OUT_TIME_W-1:0];
  endfunction

  // update the table for one accepted word and queue the dispatch words it causes
  task automatic predict_dispatch(cmd_word_t w);
    logic [63:0] now;
    logic [63:0] finish;
    logic [63:0] earliest;
    int sel;
    int k;
    int issued;
    bit found;
    dispatch_t d;
    if (w.cmd == CMD_LOAD) begin
      if (table_fill < TABLE_DEPTH) begin
        id_tbl[table_fill] = w.job_id;
        arrival_tbl[table_fill] = w.arr;
        service_tbl[table_fill] = w.svc;
        dispatched[table_fill] = 1'b0;
        table_fill++;
      end else begin
        loads_dropped = 1'b1;
      end
    end else if (table_fill == 0) begin
      d = '0;
      d.empty_run = 1'b1;
      dispatch_expected.push_back(d);
    end else begin
      now = '0;
      for (issued = 0; issued < table_fill; issued++) begin
        sel = shortest_ready(now);
        if (sel < 0) begin
          // cpu idle: jump to the earliest pending arrival
          found = 1'b0;
          earliest = '0;
          for (k = 0; k < table_fill; k++) begin
            if (!dispatched[k] && (!found || 64'(arrival_tbl[k]) < earliest)) begin
              earliest = 64'(arrival_tbl[k]);
              found = 1'b1;
            end
          end
          now = earliest;
          sel = shortest_ready(now);
        end
        finish = now + 64'(service_tbl[sel]);
        d.job_id = id_tbl[sel];
        d.start_at = clip_time(now);
        d.turnaround = clip_time(finish - 64'(arrival_tbl[sel]));
        d.last = (issued == table_fill - 1);
        d.overflow = loads_dropped;
        d.empty_run = 1'b0;
        dispatch_expected.push_back(d);
        dispatched[sel] = 1'b1;
        now = finish;
      end
      for (k = 0; k < TABLE_DEPTH; k++) dispatched[k] = 1'b0;
      table_fill = 0;
      loads_dropped = 1'b0;
    end
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_word(logic cmd, logic [15:0] job_id, logic [15:0] arr,
                            logic [15:0] svc, logic [1:0] phase, bit hold);
    cmd_word_t w;
    w.hold = hold;
    w.phase = phase;
    w.cmd = cmd;
    w.job_id = job_id;
    w.arr = arr;
    w.svc = svc;
    cmd_backlog.push_back(w);
  endtask

  // mostly short times so jobs overlap and tie, sometimes the full range
  function automatic logic [15:0] rand_time();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(7));
      default: return 16'($urandom_range(63));
    endcase
  endfunction

  // a batch of n random loads closed by a run
  task automatic queue_jobs(int n, logic [1:0] phase, bit hold);
    int i;
    for (i = 0; i < n; i++)
      queue_word(CMD_LOAD, 16'($urandom_range(65535)), rand_time(), rand_time(), phase,
                 hold && i == 0);
    queue_word(CMD_RUN, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), phase, 1'b0);
  endtask

  // driver: new words go out on the falling edge, a word on offer holds until taken
  always @(negedge clk_i) begin
    cmd_word_t w;
    bit offer;
    offer = 1'b0;
    w = '0;
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct[rx_phase]);
    if (rst_ni && !(s_axis_tvalid_i && !word_taken)) begin
      word_taken = 1'b0;
      if (cmd_backlog.size() != 0) begin
        w = cmd_backlog[0];
        offer = !(w.hold && dispatch_expected.size() != 0) &&
                ($urandom_range(99) >= send_idle_pct[w.phase]);
      end
      s_axis_tvalid_i <= offer;
      s_axis_tuser_i <= offer ? w.cmd : 1'($urandom_range(1));
      s_axis_tdata_i <= offer ? {w.svc, w.arr, w.job_id} : 48'({$urandom(), $urandom()});
    end
  end

  // monitor: both handshakes sampled on the rising edge, plus the watchdog
  always @(posedge clk_i) begin
    cmd_word_t w;
    dispatch_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        w = cmd_backlog.pop_front();
        predict_dispatch(w);
        rx_phase = w.phase;
        word_taken = 1'b1;
        if (w.cmd == CMD_LOAD) loads_taken++;
        else runs_taken++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (dispatch_expected.size() == 0) begin
          $error("dispatch word with none expected: tdata %h", m_axis_tdata_o);
          mismatches++;
        end else begin
          want = dispatch_expected.pop_front();
          compare_field("job_id_res", 32'(want.job_id), 32'(m_axis_tdata_o[15:0]));
          compare_field("start_time", 32'(want.start_at), 32'(m_axis_tdata_o[37:16]));
          compare_field("turnaround", 32'(want.turnaround), 32'(m_axis_tdata_o[59:38]));
          compare_field("last", 32'(want.last), 32'(m_axis_tlast_o));
          compare_field("overflow", 32'(want.overflow), 32'(m_axis_tuser_o[0]));
          compare_field("empty_run", 32'(want.empty_run), 32'(m_axis_tuser_o[1]));
          dispatch_words++;
          if (want.overflow) overflow_words++;
          if (want.empty_run) empty_words++;
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int target;
    bit first;

    // directed: run on an empty table
    queue_word(CMD_RUN, 16'h0000, 16'h0000, 16'h0000, 2'd0, 1'b0);
    // field extremes; the second job arrives exactly when the first ends
    queue_word(CMD_LOAD, 16'hffff, 16'h0000, 16'hffff, 2'd0, 1'b0);
    queue_word(CMD_LOAD, 16'h0000, 16'hffff, 16'h0000, 2'd0, 1'b0);
    queue_word(CMD_RUN, 16'hffff, 16'hffff, 16'hffff, 2'd0, 1'b0);
    // equal service times go to the later load
    queue_word(CMD_LOAD, 16'd1, 16'd0, 16'd5, 2'd0, 1'b0);
    queue_word(CMD_LOAD, 16'd2, 16'd0, 16'd5, 2'd0, 1'b0);
    queue_word(CMD_LOAD, 16'd3, 16'd0, 16'd5, 2'd0, 1'b0);
    queue_word(CMD_LOAD, 16'd4, 16'd0, 16'd3, 2'd0, 1'b0);
    queue_word(CMD_RUN, 16'd0, 16'd0, 16'd0, 2'd0, 1'b0);
    // nothing arrived at time zero, and a late job waits behind a gap
    queue_word(CMD_LOAD, 16'd5, 16'd100, 16'd10, 2'd0, 1'b0);
    queue_word(CMD_LOAD, 16'd6, 16'd40, 16'd50, 2'd0, 1'b0);
    queue_word(CMD_LOAD, 16'd7, 16'd40, 16'd20, 2'd0, 1'b0);
    queue_word(CMD_RUN, 16'd0, 16'd0, 16'd0, 2'd0, 1'b0);
    // a long job that is alone at time zero runs before shorter later arrivals
    queue_word(CMD_LOAD, 16'd8, 16'd0, 16'd30, 2'd0, 1'b0);
    queue_word(CMD_LOAD, 16'd9, 16'd1, 16'd2, 2'd0, 1'b0);
    queue_word(CMD_LOAD, 16'd10, 16'd1, 16'd1, 2'd0, 1'b0);
    queue_word(CMD_RUN, 16'd0, 16'd0, 16'd0, 2'd0, 1'b0);
    // back-to-back run finds the table emptied
    queue_word(CMD_RUN, 16'd0, 16'd0, 16'd0, 2'd0, 1'b0);
    // single zero-length job
    queue_word(CMD_LOAD, 16'h1234, 16'd7, 16'd0, 2'd0, 1'b0);
    queue_word(CMD_RUN, 16'h5555, 16'haaaa, 16'h5555, 2'd0, 1'b0);

    // random batches per idle mix; each later phase starts after a full drain
    for (p = 0; p < 4; p++) begin
      first = (p > 0);
      if (p == 1) begin
        // full table with a few dropped loads behind it
        queue_jobs(TABLE_DEPTH + $urandom_range(1, 3), 2'(p), first);
        first = 1'b0;
      end
      target = cmd_backlog.size() + 10;
      while (cmd_backlog.size() < target) begin
        case ($urandom_range(9))
          0: queue_word(CMD_RUN, 16'($urandom_range(65535)), rand_time(), rand_time(),
                        2'(p), first);
          1: queue_word(CMD_LOAD, 16'($urandom_range(65535)), rand_time(), rand_time(),
                        2'(p), first);
          default: queue_jobs($urandom_range(1, 6), 2'(p), first);
        endcase
        first = 1'b0;
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || dispatch_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("sent %0d loads and %0d runs under four idle/stall mixes", loads_taken,
             runs_taken);
    $display("checked %0d dispatch words, %0d with overflow set, %0d empty runs",
             dispatch_words, overflow_words, empty_words);
    if (mismatches == 0 && dispatch_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/sjn_pkg.sv
sv/sjn_ram.sv
sv/sjn_ctrl.sv
sv/sjn_dp.sv
sv/shortest_job_next_scheduler.sv
test/tb.sv
